// ===== rtl/lncp_pkg.sv =====
// Package for the letter-number command parser: constants, types and the byte classifier.
`default_nettype none
package lncp_pkg;

  localparam int unsigned MaxDigits = 10;
  localparam int unsigned CountW    = $clog2(MaxDigits + 2);
  localparam int unsigned ValueW    = 32;
  localparam int unsigned ByteW     = 8;

  localparam logic [CountW-1:0] CountLimit = CountW'(MaxDigits + 1);

  localparam logic [ByteW-1:0] ChComma = 8'h2C;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChUpA   = 8'h41;
  localparam logic [ByteW-1:0] ChUpZ   = 8'h5A;
  localparam logic [ByteW-1:0] ChLoA   = 8'h61;
  localparam logic [ByteW-1:0] ChLoZ   = 8'h7A;

  typedef enum logic [1:0] {
    CLS_LETTER,
    CLS_DIGIT,
    CLS_COMMA,
    CLS_OTHER
  } char_class_e;

  typedef struct packed {
    logic              emit;
    logic [ByteW-1:0]  letter;
    logic [ValueW-1:0] value;
  } result_t;

  function automatic char_class_e classify(input logic [ByteW-1:0] c);
    char_class_e cls;
    if ((c >= ChUpA && c <= ChUpZ) || (c >= ChLoA && c <= ChLoZ)) begin
      cls = CLS_LETTER;
    end else if (c >= ChZero && c <= ChNine) begin
      cls = CLS_DIGIT;
    end else if (c == ChComma) begin
      cls = CLS_COMMA;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lncp_in_reg.sv =====
// Input register: holds one received byte until the parser core takes it.
`default_nettype none
module lncp_in_reg (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [lncp_pkg::ByteW-1:0] in_byte_i,
  input  wire logic                     take_i,
  output logic                          valid_o,
  output logic [lncp_pkg::ByteW-1:0]    byte_o
);

  logic                       valid_q, valid_d;
  logic [lncp_pkg::ByteW-1:0] byte_q;
  logic                       in_fire;

  assign in_ready_o = !valid_q || take_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule
`default_nettype wire

// ===== rtl/lncp_core.sv =====
// Parser core: command state, digit accumulation with saturation, and result forming.
`default_nettype none
module lncp_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire logic [lncp_pkg::ByteW-1:0] byte_i,
  input  wire logic                       out_free_i,
  output logic                            take_o,
  output lncp_pkg::result_t               result_o
);

  localparam int unsigned WideW = lncp_pkg::ValueW + 4;

  logic [lncp_pkg::ByteW-1:0]  letter_q, letter_d;
  logic [lncp_pkg::CountW-1:0] count_q, count_d;
  logic [lncp_pkg::ValueW-1:0] value_q, value_d;
  lncp_pkg::char_class_e       cls;
  logic                        open_cmd;
  logic                        emit;
  logic [WideW-1:0]            wide;
  logic [lncp_pkg::ValueW-1:0] appended;
  logic [3:0]                  digit;

  assign cls      = lncp_pkg::classify(byte_i);
  assign open_cmd = (count_q != '0);
  assign emit     = (cls == lncp_pkg::CLS_COMMA) && open_cmd;

  // a byte that yields nothing never waits on the output side
  assign take_o = valid_i && (!emit || out_free_i);

  assign digit = 4'(byte_i - lncp_pkg::ChZero);
  // v*10 + d as (v<<3) + (v<<1) + d, saturate on carry out of 32 bits
  assign wide  = ({4'b0, value_q} << 3) + ({4'b0, value_q} << 1) + WideW'(digit);
  assign appended = (|wide[WideW-1:lncp_pkg::ValueW]) ? '1 : wide[lncp_pkg::ValueW-1:0];

  always_comb begin
    letter_d = letter_q;
    count_d  = count_q;
    value_d  = value_q;
    case (cls)
      lncp_pkg::CLS_LETTER: begin
        letter_d = byte_i;
        count_d  = lncp_pkg::CountW'(1);
        value_d  = '0;
      end
      lncp_pkg::CLS_DIGIT: begin
        if (open_cmd && count_q < lncp_pkg::CountLimit) begin
          value_d = appended;
          count_d = count_q + lncp_pkg::CountW'(1);
        end else begin
          count_d = '0;
          value_d = '0;
        end
      end
      default: begin
        count_d = '0;
        value_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_q <= '0;
      count_q  <= '0;
      value_q  <= '0;
    end else if (take_o) begin
      letter_q <= letter_d;
      count_q  <= count_d;
      value_q  <= value_d;
    end
  end

  assign result_o.emit   = take_o && emit;
  assign result_o.letter = letter_q;
  assign result_o.value  = value_q;

endmodule
`default_nettype wire

// ===== rtl/lncp_out_reg.sv =====
// Output register: holds one finished command until the consumer takes it.
`default_nettype none
module lncp_out_reg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lncp_pkg::result_t           result_i,
  output logic                             free_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [lncp_pkg::ByteW-1:0]       cmd_letter_o,
  output logic [lncp_pkg::ValueW-1:0]      cmd_value_o
);

  logic                        valid_q, valid_d;
  logic [lncp_pkg::ByteW-1:0]  letter_q;
  logic [lncp_pkg::ValueW-1:0] value_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (result_i.emit) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.emit) begin
      letter_q <= result_i.letter;
      value_q  <= result_i.value;
    end
  end

  assign out_valid_o  = valid_q;
  assign cmd_letter_o = letter_q;
  assign cmd_value_o  = value_q;

endmodule
`default_nettype wire

// ===== rtl/letter_number_command_parser.sv =====
// A byte is registered in the input register on accept and processed by the core from there;
// a comma's result is registered in the output register when the core takes the comma.
// Throughput: one byte per cycle; the input register stalls only while a comma
// waits on a full output register that the consumer is not taking.
// Reset (async, active low) closes any open command and empties both registers.
`default_nettype none
module letter_number_command_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [lncp_pkg::ByteW-1:0] in_byte_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [lncp_pkg::ByteW-1:0]      cmd_letter_o,
  output logic [lncp_pkg::ValueW-1:0]     cmd_value_o
);

  logic                       s1_valid;
  logic [lncp_pkg::ByteW-1:0] s1_byte;
  logic                       take;
  logic                       out_free;
  lncp_pkg::result_t          result;

  lncp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .take_i     (take),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  lncp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid),
    .byte_i     (s1_byte),
    .out_free_i (out_free),
    .take_o     (take),
    .result_o   (result)
  );

  lncp_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .result_i     (result),
    .free_o       (out_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_letter_o (cmd_letter_o),
    .cmd_value_o  (cmd_value_o)
  );

endmodule
`default_nettype wire

// ===== rtl/lncp_checker.sv =====
// Port-level checker for the command parser, bound to the top level.
`default_nettype none
module lncp_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [lncp_pkg::ByteW-1:0] cmd_letter_o,
  input wire logic [lncp_pkg::ValueW-1:0] cmd_value_o
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(cmd_letter_o) && $stable(cmd_value_o))
    else $error("result beat changed while stalled");

  // only a letter can open a command
  a_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (cmd_letter_o >= lncp_pkg::ChUpA && cmd_letter_o <= lncp_pkg::ChUpZ) ||
      (cmd_letter_o >= lncp_pkg::ChLoA && cmd_letter_o <= lncp_pkg::ChLoZ))
    else $error("result letter is not a letter");

  // input backpressure only when a result is waiting and not being taken
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // reset empties the output by the next edge
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind letter_number_command_parser lncp_checker u_lncp_checker (.*);
`default_nettype wire

// ===== tb/letter_number_command_parser_tb.sv =====
// Testbench for the letter-number command parser: directed and random byte streams, scoreboard.
`timescale 1ns / 100ps

module letter_number_command_parser_tb;

  typedef struct packed {
    logic [lncp_pkg::ByteW-1:0]  letter;
    logic [lncp_pkg::ValueW-1:0] value;
  } command_t;

  // Tracks the parser state and the commands that are owed on the output.
  class command_tracker;
    logic [lncp_pkg::ByteW-1:0]  held_letter;
    int unsigned                 held_count;
    logic [lncp_pkg::ValueW-1:0] running_value;
    command_t                    pending_cmds[$];
    int unsigned                 n_errors;

    function new();
      held_letter   = '0;
      held_count    = 0;
      running_value = '0;
      n_errors      = 0;
    endfunction

    function void close_command();
      held_count    = 0;
      running_value = '0;
    endfunction

    function void note_byte(logic [lncp_pkg::ByteW-1:0] c);
      logic [lncp_pkg::ValueW+3:0] wide;
      command_t                    cmd;
      if ((c >= lncp_pkg::ChUpA && c <= lncp_pkg::ChUpZ) ||
          (c >= lncp_pkg::ChLoA && c <= lncp_pkg::ChLoZ)) begin
        held_letter   = c;
        held_count    = 1;
        running_value = '0;
      end else if (c >= lncp_pkg::ChZero && c <= lncp_pkg::ChNine) begin
        if (held_count > 0 && held_count < lncp_pkg::MaxDigits + 1) begin
          wide = (lncp_pkg::ValueW+4)'(running_value) * 10 +
                 (lncp_pkg::ValueW+4)'(c - lncp_pkg::ChZero);
          // saturate like a 32-bit strtoul
          running_value = (wide > (lncp_pkg::ValueW+4)'({lncp_pkg::ValueW{1'b1}})) ?
                          '1 : wide[lncp_pkg::ValueW-1:0];
          held_count++;
        end else begin
          close_command();
        end
      end else if (c == lncp_pkg::ChComma) begin
        if (held_count > 0) begin
          cmd.letter = held_letter;
          cmd.value  = running_value;
          pending_cmds.push_back(cmd);
        end
        close_command();
      end else begin
        close_command();
      end
    endfunction

    function void check_command(logic [lncp_pkg::ByteW-1:0] letter,
                                logic [lncp_pkg::ValueW-1:0] value);
      command_t want;
      if (pending_cmds.size() == 0) begin
        $error("unexpected command: cmd_letter %h cmd_value %0d", letter, value);
        n_errors++;
      end else begin
        want = pending_cmds.pop_front();
        if (letter !== want.letter) begin
          $error("cmd_letter: expected %h, got %h", want.letter, letter);
          n_errors++;
        end
        if (value !== want.value) begin
          $error("cmd_value: expected %0d, got %0d", want.value, value);
          n_errors++;
        end
      end
    endfunction
  endclass

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [lncp_pkg::ByteW-1:0]  in_byte_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [lncp_pkg::ByteW-1:0]  cmd_letter_o;
  logic [lncp_pkg::ValueW-1:0] cmd_value_o;

  command_tracker tracker;
  int unsigned    idle_pct  = 0;
  int unsigned    stall_pct = 0;
  int unsigned    n_sent    = 0;

  letter_number_command_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_letter_o (cmd_letter_o),
    .cmd_value_o  (cmd_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Observe both channels at the edge, before any update lands.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      tracker.note_byte(in_byte_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_command(cmd_letter_o, cmd_value_o);
    end
  end

  task automatic send_byte(input logic [lncp_pkg::ByteW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  // Hold the input idle until every owed command has come out.
  task automatic drain_commands();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_cmds.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic [lncp_pkg::ByteW-1:0] random_letter();
    return ($urandom_range(1) ? lncp_pkg::ChUpA : lncp_pkg::ChLoA) +
           lncp_pkg::ByteW'($urandom_range(25));
  endfunction

  task automatic send_command();
    int unsigned kind;
    int unsigned pick;
    int unsigned n_digits;
    kind = $urandom_range(99);
    pick = $urandom_range(99);
    if (pick < 50)      n_digits = $urandom_range(3);
    else if (pick < 85) n_digits = $urandom_range(lncp_pkg::MaxDigits);
    else if (pick < 95) n_digits = lncp_pkg::MaxDigits;
    else                n_digits = lncp_pkg::MaxDigits + 1;
    send_byte(random_letter());
    for (int i = 0; i < n_digits; i++) begin
      send_byte(lncp_pkg::ChZero + lncp_pkg::ByteW'($urandom_range(9)));
    end
    // a few commands get a stray byte and some lose their comma
    if (kind < 8) send_byte(lncp_pkg::ByteW'($urandom_range(255)));
    if (kind >= 4) send_byte(lncp_pkg::ChComma);
  endtask

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned target;
    tracker = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty argument, lone comma, lone digit, overflow, too many digits,
    // high byte inside a command, letter restarting a command
    send_text("A,");
    send_text(",");
    send_text("5");
    send_text("z4294967296,");
    send_text("a12345678901,");
    send_text("Q7");
    send_byte(8'hFF);
    send_text(",B3Z0,");
    drain_commands();

    target = n_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      target += 200;
      while (n_sent < target) begin
        if ($urandom_range(9) == 0) send_byte(lncp_pkg::ByteW'($urandom_range(255)));
        else send_command();
      end
      drain_commands();
    end

    repeat (10) @(posedge clk_i);
    if (tracker.n_errors == 0 && tracker.pending_cmds.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
